[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Property macros shared by the stack machine execute core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHECK_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/smx_pkg.sv]
// ----------------------------------------------------------------------------
// smx_pkg
// Opcodes, status codes, register indexes and shared types of the stack
// machine execute core.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int CMD_W     = 4;
    localparam int WORD_W    = 32;
    localparam int ADDR_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LD  = 4'd0,
        CMD_ST  = 4'd1,
        CMD_LDC = 4'd2,
        CMD_ADD = 4'd3,
        CMD_SUB = 4'd4,
        CMD_CMP = 4'd5,
        CMD_JMP = 4'd6,
        CMD_BR  = 4'd7,
        CMD_RET = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_RUN       = 3'd0,
        ST_RETURN    = 3'd1,
        ST_PAST_END  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_BAD_JUMP  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        EX_CLEAR,
        EX_TAKE,
        EX_DO
    } exec_state_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CHECK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN    = 8'd1;

    typedef struct packed {
        logic              depth_check;
        logic [ADDR_W-1:0] program_length;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] next_address;
        status_t           status;
        logic [WORD_W-1:0] top_value;
    } result_t;

endpackage

[rtl/stack_machine_execute_core.sv]
// A word accepted at the input passes three index stages, the memory read in
// the execute unit's take state and then its execute state, plus output wait.
// A new word is taken only once the last one is written back, set by the
// read-then-write pair on the stack and data memories in the execute unit.
// Reset: control clears at once; then a clearing pass zeroes the data memory
// word by word, during which in_stall stays high.
// ----------------------------------------------------------------------------
// stack_machine_execute_core
// Executes one stack-machine instruction per input word and returns the next
// pointer, status, top of stack and stack depth as one result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_machine_execute_core #(
    parameter int DATA_WORDS  = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [smx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smx_pkg::CFG_DAT_W-1:0]      cfg_data,
    // instructions
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [smx_pkg::CMD_W-1:0]          command,
    input  logic [smx_pkg::WORD_W-1:0]         argument,
    // results
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [smx_pkg::ADDR_W-1:0]         next_address,
    output logic [2:0]                         status,
    output logic [smx_pkg::WORD_W-1:0]         top_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0]   stack_count
);
    import smx_pkg::*;

    localparam int IDX_W = $clog2(DATA_WORDS);
    localparam int SC_W  = $clog2(STACK_DEPTH + 1);

    logic              depth_check_reg, depth_check_next;
    logic [ADDR_W-1:0] prog_len_reg, prog_len_next;
    cfg_t              cfg;

    logic              idx_valid, idx_ready;
    logic [CMD_W-1:0]  idx_command;
    logic [WORD_W-1:0] idx_argument;
    logic [IDX_W-1:0]  idx_didx;

    logic              out_free, ex_done, ex_clearing;
    result_t           ex_result;
    logic [SC_W-1:0]   ex_count;

    logic              out_valid_reg, out_valid_next;
    result_t           result_reg;
    logic [SC_W-1:0]   count_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        depth_check_next = depth_check_reg;
        prog_len_next    = prog_len_reg;
        if (cfg_valid && cfg_index == CFG_DEPTH_CHECK)
            depth_check_next = cfg_data[0];
        if (cfg_valid && cfg_index == CFG_PROG_LEN)
            prog_len_next = cfg_data[ADDR_W-1:0];
    end

    assign cfg.depth_check    = depth_check_reg;
    assign cfg.program_length = prog_len_reg;

    // ---------------- datapath ----------------
    smx_index #(
        .DATA_WORDS (DATA_WORDS)
    ) u_index (
        .clk          (clk),
        .rst_n        (rst_n),
        .hold         (ex_clearing),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .argument     (argument),
        .idx_valid    (idx_valid),
        .idx_ready    (idx_ready),
        .idx_command  (idx_command),
        .idx_argument (idx_argument),
        .idx_didx     (idx_didx)
    );

    smx_exec #(
        .DATA_WORDS  (DATA_WORDS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .idx_valid    (idx_valid),
        .idx_ready    (idx_ready),
        .idx_command  (idx_command),
        .idx_argument (idx_argument),
        .idx_didx     (idx_didx),
        .out_free     (out_free),
        .res_done     (ex_done),
        .result       (ex_result),
        .res_count    (ex_count),
        .clearing     (ex_clearing)
    );

    // ---------------- output register ----------------
    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid_next = ex_done || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            depth_check_reg <= 1'b0;
            prog_len_reg    <= '0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            depth_check_reg <= depth_check_next;
            prog_len_reg    <= prog_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_done)
        begin
            result_reg <= ex_result;
            count_reg  <= ex_count;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_address = result_reg.next_address;
    assign status       = result_reg.status;
    assign top_value    = result_reg.top_value;
    assign stack_count  = count_reg;

    // ---------------- checks ----------------
    `CHECK_IMPLIES(a_clear_blocks_input, clk, rst_n, ex_clearing, in_stall)
    `CHECK_NEXT(a_done_reaches_output, clk, rst_n, ex_done, out_valid)
    `CHECK_IMPLIES(a_empty_top_zero, clk, rst_n, out_valid && stack_count == '0, top_value == '0)
    `CHECK_IMPLIES(a_depth_bound, clk, rst_n, out_valid, stack_count <= SC_W'(STACK_DEPTH))

endmodule

[rtl/smx_index.sv]
// ----------------------------------------------------------------------------
// smx_index
// Three-stage front end: reduces the signed argument modulo DATA_WORDS
// (byte folding, reciprocal multiply, remainder) and carries the word along.
// ----------------------------------------------------------------------------
module smx_index #(
    parameter int DATA_WORDS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             hold,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [smx_pkg::CMD_W-1:0]        command,
    input  logic [smx_pkg::WORD_W-1:0]       argument,
    output logic                             idx_valid,
    input  logic                             idx_ready,
    output logic [smx_pkg::CMD_W-1:0]        idx_command,
    output logic [smx_pkg::WORD_W-1:0]       idx_argument,
    output logic [$clog2(DATA_WORDS)-1:0]    idx_didx
);
    import smx_pkg::*;

    localparam int IDX_W = $clog2(DATA_WORDS);
    // folded sum stays below 2^27
    localparam int X_W   = 27;
    localparam int M_W   = 29;
    localparam int P_W   = X_W + M_W;
    localparam int SHIFT = X_W + IDX_W;

    localparam logic [63:0] NW    = 64'(DATA_WORDS);
    localparam logic [15:0] C0    = 16'(64'd1 % NW);
    localparam logic [15:0] C1    = 16'(64'd256 % NW);
    localparam logic [15:0] C2    = 16'(64'd65536 % NW);
    localparam logic [15:0] C3    = 16'(64'd16777216 % NW);
    // a negative word is u - 2^32, folded in as an additive constant
    localparam logic [15:0] CNEG  = 16'((NW - (64'd4294967296 % NW)) % NW);
    localparam logic [M_W-1:0] MULT = M_W'(((64'd1 << SHIFT) + NW - 64'd1) / NW);

    logic                  v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic                  move1, move2, move3, accept;
    logic [X_W-1:0]        x1_next, x1_reg, x2_reg, q2_next, q2_reg, qn, rem;
    logic [P_W-1:0]        prod;
    logic [CMD_W-1:0]      cmd1_reg, cmd2_reg, cmd3_reg;
    logic [WORD_W-1:0]     arg1_reg, arg2_reg, arg3_reg;
    logic [IDX_W-1:0]      didx3_reg;

    assign move3    = !v3_reg || idx_ready;
    assign move2    = !v2_reg || move3;
    assign move1    = !v1_reg || move2;
    assign in_stall = hold || !move1;
    assign accept   = in_valid && !in_stall;

    assign v1_next = move1 ? accept : v1_reg;
    assign v2_next = move2 ? v1_reg : v2_reg;
    assign v3_next = move3 ? v2_reg : v3_reg;

    always_comb
    begin
        x1_next = X_W'(argument[7:0])   * X_W'(C0)
                + X_W'(argument[15:8])  * X_W'(C1)
                + X_W'(argument[23:16]) * X_W'(C2)
                + X_W'(argument[31:24]) * X_W'(C3)
                + (argument[31] ? X_W'(CNEG) : X_W'(0));
    end

    assign prod    = P_W'(x1_reg) * P_W'(MULT);
    assign q2_next = X_W'(prod >> SHIFT);
    assign qn      = q2_reg * X_W'(DATA_WORDS);
    assign rem     = x2_reg - qn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move1)
        begin
            x1_reg   <= x1_next;
            cmd1_reg <= command;
            arg1_reg <= argument;
        end
        if (move2)
        begin
            x2_reg   <= x1_reg;
            q2_reg   <= q2_next;
            cmd2_reg <= cmd1_reg;
            arg2_reg <= arg1_reg;
        end
        if (move3)
        begin
            didx3_reg <= rem[IDX_W-1:0];
            cmd3_reg  <= cmd2_reg;
            arg3_reg  <= arg2_reg;
        end
    end

    assign idx_valid    = v3_reg;
    assign idx_command  = cmd3_reg;
    assign idx_argument = arg3_reg;
    assign idx_didx     = didx3_reg;

endmodule

[rtl/smx_exec.sv]
// ----------------------------------------------------------------------------
// smx_exec
// Execute unit: stack and data memories, pointer and halt state. Reads in
// the take cycle, computes and writes back in the do state once the output is free.
// ----------------------------------------------------------------------------
module smx_exec #(
    parameter int DATA_WORDS  = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smx_pkg::cfg_t                      cfg,
    input  logic                               idx_valid,
    output logic                               idx_ready,
    input  logic [smx_pkg::CMD_W-1:0]          idx_command,
    input  logic [smx_pkg::WORD_W-1:0]         idx_argument,
    input  logic [$clog2(DATA_WORDS)-1:0]      idx_didx,
    input  logic                               out_free,
    output logic                               res_done,
    output smx_pkg::result_t                   result,
    output logic [$clog2(STACK_DEPTH+1)-1:0]   res_count,
    output logic                               clearing
);
    import smx_pkg::*;

    localparam int IDX_W = $clog2(DATA_WORDS);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int SC_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [SC_W-1:0]  DEPTH_C   = SC_W'(STACK_DEPTH);
    localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(DATA_WORDS - 1);

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] data_mem  [DATA_WORDS];

    exec_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [SC_W-1:0]   count_reg, count_next, count_new, cnt_m1, cnt_m2;
    logic [ADDR_W-1:0] ip_reg, ip_next, ip_new, seq_ip, nxt;
    logic              halted_reg, halted_next, halted_new;
    status_t           code_reg, code_next, code_new;
    logic [CMD_W-1:0]  cmd_reg;
    logic [WORD_W-1:0] arg_reg, rd_a_reg, rd_b_reg, rd_d_reg;
    logic [IDX_W-1:0]  didx_reg;

    logic              take, commit;
    logic [SA_W-1:0]   addr_a, addr_b;
    logic [WORD_W-1:0] a, b, push_val, cmp_val, top_new;
    logic              push, do_push, pop, store, jump, underflow, target_ok;

    logic              stk_we, dat_we;
    logic [IDX_W-1:0]  dat_waddr;
    logic [WORD_W-1:0] dat_wdata;

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= EX_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            ip_reg       <= '0;
            halted_reg   <= 1'b0;
            code_reg     <= ST_RUN;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            ip_reg       <= ip_next;
            halted_reg   <= halted_next;
            code_reg     <= code_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clearing      = 1'b0;
        idx_ready     = 1'b0;
        commit        = 1'b0;
        unique case (state_reg)
            EX_CLEAR:
            begin
                clearing      = 1'b1;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_WORD)
                    state_next = EX_TAKE;
            end
            EX_TAKE:
            begin
                idx_ready = 1'b1;
                if (idx_valid)
                    state_next = EX_DO;
            end
            EX_DO:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = EX_TAKE;
                end
            end
            default:
            begin
                state_next = EX_CLEAR;
            end
        endcase
    end

    assign take     = idx_ready && idx_valid;
    assign res_done = commit;

    // ---------------- memories ----------------
    assign cnt_m1 = count_reg - SC_W'(1);
    assign cnt_m2 = count_reg - SC_W'(2);
    assign addr_a = (count_reg != '0)        ? cnt_m1[SA_W-1:0] : '0;
    assign addr_b = (count_reg > SC_W'(1))   ? cnt_m2[SA_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[count_reg[SA_W-1:0]] <= push_val;
        if (take)
        begin
            rd_a_reg <= stack_mem[addr_a];
            rd_b_reg <= stack_mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dat_we)
            data_mem[dat_waddr] <= dat_wdata;
        if (take)
            rd_d_reg <= data_mem[idx_didx];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg  <= idx_command;
            arg_reg  <= idx_argument;
            didx_reg <= idx_didx;
        end
    end

    // ---------------- execute ----------------
    assign a = (count_reg != '0)      ? rd_a_reg : '0;
    assign b = (count_reg > SC_W'(1)) ? rd_b_reg : '0;

    always_comb
    begin
        if ($signed(a) > $signed(b))
            cmp_val = WORD_W'(1);
        else if ($signed(a) < $signed(b))
            cmp_val = '1;
        else
            cmp_val = '0;
    end

    assign seq_ip    = ip_reg + ADDR_W'(1);
    assign target_ok = (arg_reg[WORD_W-1:ADDR_W] == '0);
    assign underflow = ((cmd_reg == CMD_ST || cmd_reg == CMD_BR) && count_reg == '0)
                    || ((cmd_reg == CMD_ADD || cmd_reg == CMD_SUB || cmd_reg == CMD_CMP)
                        && count_reg < SC_W'(2));

    always_comb
    begin
        halted_new = halted_reg;
        code_new   = code_reg;
        count_new  = count_reg;
        ip_new     = ip_reg;
        push       = 1'b0;
        do_push    = 1'b0;
        push_val   = '0;
        pop        = 1'b0;
        store      = 1'b0;
        jump       = 1'b0;
        nxt        = seq_ip;
        if (halted_reg)
        begin
            halted_new = 1'b1;
        end
        else if (ip_reg >= cfg.program_length)
        begin
            halted_new = 1'b1;
            code_new   = ST_PAST_END;
        end
        else if (cfg.depth_check && underflow)
        begin
            halted_new = 1'b1;
            code_new   = ST_UNDERFLOW;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_LD:
                begin
                    push     = 1'b1;
                    push_val = rd_d_reg;
                end
                CMD_ST:
                begin
                    store = 1'b1;
                    pop   = (count_reg != '0);
                end
                CMD_LDC:
                begin
                    push     = 1'b1;
                    push_val = arg_reg;
                end
                CMD_ADD:
                begin
                    push     = 1'b1;
                    push_val = a + b;
                end
                CMD_SUB:
                begin
                    push     = 1'b1;
                    push_val = a - b;
                end
                CMD_CMP:
                begin
                    push     = 1'b1;
                    push_val = cmp_val;
                end
                CMD_JMP: jump = 1'b1;
                CMD_BR:  jump = (a != '0);
                CMD_RET:
                begin
                    halted_new = 1'b1;
                    code_new   = ST_RETURN;
                end
                default: ;
            endcase

            if (push)
            begin
                if (count_reg >= DEPTH_C)
                begin
                    halted_new = 1'b1;
                    code_new   = ST_OVERFLOW;
                end
                else
                begin
                    do_push   = 1'b1;
                    count_new = count_reg + SC_W'(1);
                end
            end
            if (pop)
                count_new = cnt_m1;
            if (jump)
            begin
                if (!target_ok)
                begin
                    halted_new = 1'b1;
                    code_new   = ST_BAD_JUMP;
                end
                else
                    nxt = arg_reg[ADDR_W-1:0];
            end
            // a return still advances the pointer; other halts keep it
            if (!halted_new || code_new == ST_RETURN)
            begin
                ip_new = nxt;
                if (!halted_new && nxt >= cfg.program_length)
                begin
                    halted_new = 1'b1;
                    code_new   = ST_PAST_END;
                end
            end
        end
    end

    always_comb
    begin
        if (do_push)
            top_new = push_val;
        else if (pop)
            top_new = b;
        else
            top_new = a;
    end

    assign count_next  = commit ? count_new  : count_reg;
    assign ip_next     = commit ? ip_new     : ip_reg;
    assign halted_next = commit ? halted_new : halted_reg;
    assign code_next   = commit ? code_new   : code_reg;

    assign stk_we    = commit && do_push;
    assign dat_we    = clearing || (commit && store);
    assign dat_waddr = clearing ? clr_addr_reg : didx_reg;
    assign dat_wdata = clearing ? '0 : a;

    assign result.next_address = ip_new;
    assign result.status       = halted_new ? code_new : ST_RUN;
    assign result.top_value    = top_new;
    assign res_count           = count_new;

endmodule

[sim/stack_machine_execute_core_tb.sv]
// ----------------------------------------------------------------------------
// stack_machine_execute_core_tb
// Self-checking bench for the stack machine execute core. A cycle-free model
// of the machine predicts next pointer, status, top and depth for every
// instruction word. Directed opcode corners come first, then random programs
// in safe, unsafe and short-program settings, the first two with random
// idling on both sides, a long output hold-off, and finally one randomly chosen halt.
// ----------------------------------------------------------------------------
module stack_machine_execute_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import smx_pkg::*;

    localparam int STACK_WORDS  = 64;
    localparam int DATA_SLOTS   = 256;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;

    localparam logic [CMD_W-1:0]     NOP_FIRST  = 4'd9;
    localparam logic [CMD_W-1:0]     NOP_LAST   = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;

    typedef struct {
        logic [ADDR_W-1:0] next_address;
        status_t           status;
        logic [WORD_W-1:0] top_value;
        logic [6:0]        stack_count;
    } step_outcome_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      command   = '0;
    logic [WORD_W-1:0]     argument  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b1;
    logic [ADDR_W-1:0]     next_address;
    logic [2:0]            status;
    logic [WORD_W-1:0]     top_value;
    logic [6:0]            stack_count;

    // machine copy kept by the bench
    logic [WORD_W-1:0]  stack_mem [STACK_WORDS];
    int unsigned        depth_m;
    logic [WORD_W-1:0]  data_mem [DATA_SLOTS];
    logic [ADDR_W-1:0]  pc_m;
    bit                 halted_m;
    status_t            halt_code_m;
    bit                 safe_m;
    logic [ADDR_W-1:0]  plen_m;

    step_outcome_t awaited_results [$];

    bit    quiet = 1'b0;
    int    hold_req = 0;
    int    hold_ack = 0;
    int    hold_left = 0;
    int    cycle_count = 0;
    int    errors = 0;
    int    words_sent = 0;
    int    results_checked = 0;
    int    input_stall_cycles = 0;
    string halt_kind = "none";

    stack_machine_execute_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .argument     (argument),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .next_address (next_address),
        .status       (status),
        .top_value    (top_value),
        .stack_count  (stack_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // machine model
    // ------------------------------------------------------------------
    function automatic void clear_machine();
        foreach (stack_mem[i]) stack_mem[i] = '0;
        foreach (data_mem[i]) data_mem[i] = '0;
        depth_m     = 0;
        pc_m        = '0;
        halted_m    = 1'b0;
        halt_code_m = ST_RUN;
        safe_m      = 1'b0;
        plen_m      = '0;
    endfunction

    function automatic logic [WORD_W-1:0] stack_peek(int unsigned below_top);
        if (depth_m > below_top)
            return stack_mem[depth_m - 1 - below_top];
        return '0;
    endfunction

    function automatic void enter_halt(status_t code);
        halted_m    = 1'b1;
        halt_code_m = code;
    endfunction

    function automatic void push_word(logic [WORD_W-1:0] v);
        if (depth_m >= STACK_WORDS)
            enter_halt(ST_OVERFLOW);
        else
        begin
            stack_mem[depth_m] = v;
            depth_m++;
        end
    endfunction

    function automatic step_outcome_t execute_word(logic [CMD_W-1:0] cmd,
                                                   logic [WORD_W-1:0] arg);
        logic [16:0]       nxt;
        logic [7:0]        didx;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              jump;
        logic              starved;
        step_outcome_t     r;
        nxt  = {1'b0, pc_m} + 17'd1;
        // low byte of a two's complement value is its floored modulo 256
        didx = arg[7:0];
        starved = ((cmd == CMD_ST || cmd == CMD_BR) && depth_m < 1) ||
                  ((cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_CMP) && depth_m < 2);
        if (!halted_m && pc_m >= plen_m)
            enter_halt(ST_PAST_END);
        else if (!halted_m)
        begin
            if (safe_m && starved)
                enter_halt(ST_UNDERFLOW);
            else
            begin
                a    = stack_peek(0);
                b    = stack_peek(1);
                jump = 1'b0;
                case (cmd)
                    CMD_LD:  push_word(data_mem[didx]);
                    CMD_ST:
                    begin
                        data_mem[didx] = a;
                        if (depth_m > 0)
                            depth_m--;
                    end
                    CMD_LDC: push_word(arg);
                    CMD_ADD: push_word(a + b);
                    CMD_SUB: push_word(a - b);
                    CMD_CMP: push_word($signed(a) > $signed(b) ? 32'd1 :
                                       ($signed(a) < $signed(b) ? 32'hFFFF_FFFF : 32'd0));
                    CMD_JMP: jump = 1'b1;
                    CMD_BR:  jump = (a != '0);
                    CMD_RET: enter_halt(ST_RETURN);
                    default: ;
                endcase
                if (jump)
                begin
                    if ($signed(arg) < 0 || $signed(arg) > 65535)
                        enter_halt(ST_BAD_JUMP);
                    else
                        nxt = arg[16:0];
                end
                if (!halted_m || halt_code_m == ST_RETURN)
                begin
                    pc_m = nxt[15:0];
                    if (!halted_m && pc_m >= plen_m)
                        enter_halt(ST_PAST_END);
                end
            end
        end
        r.next_address = pc_m;
        r.status       = halted_m ? halt_code_m : ST_RUN;
        r.top_value    = stack_peek(0);
        r.stack_count  = depth_m[6:0];
        return r;
    endfunction

    // true when the word leaves the machine running
    function automatic bit keeps_running(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] arg);
        bit seq_ok;
        bit target_ok;
        seq_ok    = int'(pc_m) + 1 < int'(plen_m);
        target_ok = $signed(arg) >= 0 && $signed(arg) < int'(plen_m);
        case (cmd)
            CMD_LD, CMD_LDC:
                return depth_m < STACK_WORDS && seq_ok;
            CMD_ADD, CMD_SUB, CMD_CMP:
                return depth_m < STACK_WORDS && (!safe_m || depth_m >= 2) && seq_ok;
            CMD_ST:
                return (!safe_m || depth_m >= 1) && seq_ok;
            CMD_JMP:
                return target_ok;
            CMD_BR:
                return (!safe_m || depth_m >= 1) &&
                       (stack_peek(0) == '0 ? seq_ok : target_ok);
            CMD_RET:
                return 1'b0;
            default:
                return seq_ok;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_arg(logic [CMD_W-1:0] cmd);
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] corners [5] = '{32'd0, 32'd1, 32'h7FFF_FFFF,
                                           32'h8000_0000, 32'hFFFF_FFFF};
        v = $urandom;
        case (cmd)
            CMD_JMP, CMD_BR:
                if ($urandom_range(0, 9) != 0)
                    v = $urandom_range(0, int'(plen_m) - 1);
            CMD_LD, CMD_ST:
                // crowd a few slots so loads see earlier stores
                if ($urandom_range(0, 1) != 0)
                    v[7:0] = 8'($urandom_range(0, 7));
            CMD_LDC:
                case ($urandom_range(0, 7))
                    0:       v = corners[$urandom_range(0, 4)];
                    1, 2:    v = $urandom_range(0, 3);
                    default: ;
                endcase
            default: ;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] arg);
        while (!quiet && $urandom_range(0, 99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        argument <= arg;
        @(posedge clk);
        while (in_stall)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        awaited_results.push_back(execute_word(cmd, arg));
        words_sent++;
    endtask

    task automatic send_running_word();
        logic [CMD_W-1:0]  c;
        logic [WORD_W-1:0] a;
        do
        begin
            c = ($urandom_range(0, 99) < 6) ? CMD_W'($urandom_range(NOP_FIRST, NOP_LAST))
                                            : CMD_W'($urandom_range(CMD_LD, CMD_BR));
            if (depth_m > 40 && $urandom_range(0, 1) != 0)
                c = CMD_ST;
            if (int'(pc_m) + 1 >= int'(plen_m))
                c = CMD_JMP;
            a = random_arg(c);
        end
        while (!keeps_running(c, a));
        send_word(c, a);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_DEPTH_CHECK)
            safe_m = value[0];
        else if (idx == CFG_PROG_LEN)
            plen_m = value;
    endtask

    task automatic set_config(input bit safe, input logic [CFG_DAT_W-1:0] plen);
        write_reg(CFG_DEPTH_CHECK, {15'd0, safe});
        write_reg(CFG_PROG_LEN, plen);
        cfg_valid <= 1'b0;
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_ops();
        // unsafe mode, empty stack: missing operands read as zero
        send_word(CMD_ST,  32'hFFFF_FFFF);
        send_word(CMD_BR,  32'd100);
        send_word(CMD_ADD, 32'd0);
        send_word(CMD_CMP, 32'd0);
        send_word(CMD_LDC, 32'h7FFF_FFFF);
        send_word(CMD_LDC, 32'd1);
        send_word(CMD_ADD, 32'd0);           // wraps to most negative
        send_word(CMD_SUB, 32'd0);
        send_word(CMD_CMP, 32'd0);           // greater
        send_word(CMD_LDC, 32'h8000_0000);
        send_word(CMD_CMP, 32'd0);           // less
        send_word(CMD_ST,  32'h8000_0000);   // slot 0
        send_word(CMD_LD,  32'hFFFF_FF00);   // -256 lands on slot 0
        send_word(CMD_ST,  32'h7FFF_FFFF);   // slot 255
        send_word(CMD_LD,  32'hFFFF_FFFF);
        send_word(CMD_LD,  32'd300);         // never written, reads zero
        send_word(CMD_BR,  32'd1000);        // top zero, falls through
        send_word(CMD_LDC, 32'd5);
        send_word(CMD_BR,  32'd40000);
        send_word(CMD_JMP, 32'd65534);
        send_word(CMD_JMP, 32'd0);
        send_word(NOP_FIRST, 32'h0000_0000);
        send_word(NOP_LAST,  32'hFFFF_FFFF);
    endtask

    task automatic test_random_safe();
        settle();
        set_config(1'b1, 16'hFFFF);
        repeat (280) send_running_word();
    endtask

    task automatic test_back_to_back();
        int lim;
        settle();
        lim = int'(pc_m) + $urandom_range(20, 400);
        if (lim > 65535)
            lim = 65535;
        set_config(1'b0, lim[15:0]);
        quiet = 1'b1;
        repeat (140) send_running_word();
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        hold_req++;
        repeat (40) send_running_word();
        quiet = 1'b0;
    endtask

    task automatic test_random_unsafe();
        settle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        set_config(1'b0, 16'hFFFF);
        repeat (220) send_running_word();
    endtask

    task automatic test_final_halt();
        int                kind;
        cmd_t              pushers [5] = '{CMD_LD, CMD_LDC, CMD_ADD, CMD_SUB, CMD_CMP};
        cmd_t              takers  [5] = '{CMD_ST, CMD_ADD, CMD_SUB, CMD_CMP, CMD_BR};
        logic [WORD_W-1:0] wild    [4] = '{32'hFFFF_FFFF, 32'h8000_0000,
                                           32'h0001_0000, 32'h7FFF_FFFF};
        kind = $urandom_range(0, 5);
        settle();
        set_config(1'b0, 16'hFFFF);
        send_word(CMD_JMP, 32'd0);
        case (kind)
            0:
            begin
                halt_kind = "return";
                send_word(CMD_RET, $urandom);
            end
            1:
            begin
                halt_kind = "underflow";
                settle();
                set_config(1'b1, 16'hFFFF);
                while (depth_m > 0)
                    send_word(CMD_ST, $urandom);
                if ($urandom_range(0, 1) != 0)
                begin
                    send_word(CMD_LDC, $urandom);
                    send_word(takers[$urandom_range(1, 3)], $urandom);
                end
                else
                    send_word(takers[$urandom_range(0, 4)], $urandom_range(0, 9));
            end
            2:
            begin
                halt_kind = "overflow";
                while (depth_m < STACK_WORDS)
                    send_word(CMD_LDC, $urandom);
                send_word(pushers[$urandom_range(0, 4)], $urandom);
            end
            3:
            begin
                halt_kind = "bad jump target";
                if ($urandom_range(0, 1) != 0)
                begin
                    send_word(CMD_LDC, 32'd1);
                    send_word(CMD_BR, wild[$urandom_range(0, 3)]);
                end
                else
                    send_word(CMD_JMP, wild[$urandom_range(0, 3)]);
            end
            4:
            begin
                halt_kind = "zero length program";
                settle();
                set_config(1'b0, 16'h0000);
                send_word(CMD_W'($urandom_range(0, 15)), $urandom);
            end
            default:
            begin
                halt_kind = "ran off the end";
                settle();
                set_config(1'b0, pc_m + 16'd3);
                while (!halted_m)
                    send_word(CMD_W'($urandom_range(NOP_FIRST, NOP_LAST)), $urandom);
            end
        endcase
        // halted from here on, a register write must not revive it
        repeat (12) send_word(CMD_W'($urandom_range(0, 15)), $urandom);
        settle();
        set_config(!safe_m, 16'hFFFF);
        repeat (12) send_word(CMD_W'($urandom_range(0, 15)), $urandom);
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (errors < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < 31);
    end

    always @(posedge clk)
    begin
        step_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result word with no instruction outstanding");
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (next_address !== want.next_address)
                    report_mismatch($sformatf("next_address %0d, want %0d",
                                              next_address, want.next_address));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %s",
                                              status, want.status.name()));
                if (top_value !== want.top_value)
                    report_mismatch($sformatf("top_value %h, want %h",
                                              top_value, want.top_value));
                if (stack_count !== want.stack_count)
                    report_mismatch($sformatf("stack_count %0d, want %0d",
                                              stack_count, want.stack_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        clear_machine();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // length starts at zero; write it back and forth before any word
        write_reg(CFG_PROG_LEN, 16'h0000);
        set_config(1'b0, 16'hFFFF);

        test_directed_ops();
        test_random_safe();
        test_back_to_back();
        test_backpressure();
        test_random_unsafe();
        test_final_halt();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d instruction words, %0d results checked, %0d input stall cycles",
                 words_sent, results_checked, input_stall_cycles);
        $display("phases: directed, safe, short program, hold-off, unsafe; final halt: %s",
                 halt_kind);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/smx_pkg.sv
rtl/smx_index.sv
rtl/smx_exec.sv
rtl/stack_machine_execute_core.sv
sim/stack_machine_execute_core_tb.sv
